[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the throttle core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/drt_pkg.sv]
// Shared widths, codes and control structs of the dual-rate throttle core.
package drt_pkg;

    localparam int TIME_W      = 48;
    localparam int RATE_W      = 40;
    localparam int DELTA_W     = 32;
    localparam int WAIT_W      = 32;
    localparam int LEVEL_W     = 62;
    localparam int LIM_W       = 61;
    localparam int ACTIVE_W    = 16;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int STEP_W      = 6;
    // accumulator must hold the saturation cap 2^62
    localparam int SAT_MIN_W   = 63;
    localparam int CAP_SHIFT   = 62;
    // quotient bits resolved by the two divisions
    localparam int AVG_Q_BITS  = 49;
    localparam int PEAK_Q_BITS = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PROGRESS = 2'd0,
        OP_START    = 2'd1,
        OP_END      = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVG_RATE     = 2'd0,
        CFG_PEAK_RATE    = 2'd1,
        CFG_BUCKET_LIMIT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_MULSAT,
        UOP_DIV
    } unit_op_t;

    typedef struct packed {
        logic                start;
        unit_op_t            op;
        logic [STEP_W-1:0]   steps;
        logic [TIME_W-1:0]   mcand;
        logic [RATE_W-1:0]   mplier;
        logic [RATE_W-1:0]   divisor;
    } unit_cmd_t;

    typedef struct packed {
        logic done;
        logic sat;
        logic rem_nz;
    } unit_stat_t;

endpackage

[rtl/core/drt_if.sv]
// Request, result and register-write channel interfaces of the throttle core.
interface drt_item_if;
    logic                        valid;
    logic                        ready;
    logic [drt_pkg::OP_W-1:0]    op;
    logic [drt_pkg::DELTA_W-1:0] delta_bytes;
    logic [drt_pkg::TIME_W-1:0]  now_us;

    modport source (output valid, output op, output delta_bytes, output now_us, input ready);
    modport sink   (input valid, input op, input delta_bytes, input now_us, output ready);
endinterface

interface drt_result_if;
    logic                       valid;
    logic                       ready;
    logic [drt_pkg::WAIT_W-1:0] wait_us;
    logic                       by_peak;
    logic                       not_registered;

    modport source (output valid, output wait_us, output by_peak, output not_registered,
                    input ready);
    modport sink   (input valid, input wait_us, input by_peak, input not_registered,
                    output ready);
endinterface

interface drt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [drt_pkg::CFG_IDX_W-1:0] index;
    logic [drt_pkg::RATE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/drt_unit.sv]
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module drt_unit #(
    parameter int ACC_W = 68
) (
    input  logic                clk,
    input  logic                rst_n,
    input  drt_pkg::unit_cmd_t  cmd,
    input  logic [ACC_W-1:0]    dividend,
    output drt_pkg::unit_stat_t stat,
    output logic [ACC_W-1:0]    acc
);

    localparam logic [ACC_W:0] SAT_CAP = (ACC_W+1)'(1) << drt_pkg::CAP_SHIFT;

    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic [drt_pkg::RATE_W-1:0]    mpl_reg, mpl_next;
    logic [drt_pkg::TIME_W-1:0]    mcand_reg, mcand_next;
    logic [drt_pkg::RATE_W-1:0]    div_reg, div_next;
    logic [drt_pkg::RATE_W:0]      rem_reg, rem_next;
    drt_pkg::unit_op_t             op_reg, op_next;
    logic [drt_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic                          sat_reg, sat_next;

    always_comb
    begin
        logic [ACC_W:0]           prod_sum;
        logic [drt_pkg::RATE_W:0] rem_sh;
        logic                     rem_ge;
        logic [ACC_W-1:0]         div_hi;
        logic                     div_sat;

        acc_next   = acc_reg;
        mpl_next   = mpl_reg;
        mcand_next = mcand_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        sat_next   = sat_reg;
        done_next  = 1'b0;

        prod_sum = {acc_reg, 1'b0}
                 + (ACC_W+1)'(mpl_reg[drt_pkg::RATE_W-1] ? mcand_reg : '0);
        rem_sh   = {rem_reg[drt_pkg::RATE_W-1:0], acc_reg[ACC_W-1]};
        rem_ge   = rem_sh >= {1'b0, div_reg};
        // quotient bits above the resolved range only tell saturation
        div_hi   = dividend >> cmd.steps;
        div_sat  = div_hi >= ACC_W'(cmd.divisor);

        if (cmd.start)
        begin
            op_next    = cmd.op;
            cnt_next   = cmd.steps;
            run_next   = 1'b1;
            mcand_next = cmd.mcand;
            div_next   = cmd.divisor;
            if (cmd.op == drt_pkg::UOP_DIV)
            begin
                sat_next = div_sat;
                rem_next = div_sat ? '0 : div_hi[drt_pkg::RATE_W:0];
                acc_next = dividend << (ACC_W - int'(cmd.steps));
                mpl_next = '0;
            end
            else
            begin
                sat_next = 1'b0;
                rem_next = '0;
                acc_next = '0;
                mpl_next = cmd.mplier << (drt_pkg::RATE_W - int'(cmd.steps));
            end
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == drt_pkg::STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            unique case (op_reg)
                drt_pkg::UOP_DIV:
                begin
                    rem_next = rem_ge ? rem_sh - {1'b0, div_reg} : rem_sh;
                    acc_next = {acc_reg[ACC_W-2:0], rem_ge};
                end
                drt_pkg::UOP_MUL, drt_pkg::UOP_MULSAT:
                begin
                    mpl_next = mpl_reg << 1;
                    if (op_reg == drt_pkg::UOP_MULSAT && prod_sum > SAT_CAP)
                        acc_next = SAT_CAP[ACC_W-1:0];
                    else
                        acc_next = prod_sum[ACC_W-1:0];
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            mpl_reg   <= '0;
            mcand_reg <= '0;
            div_reg   <= '0;
            rem_reg   <= '0;
            op_reg    <= drt_pkg::UOP_MUL;
            cnt_reg   <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            mpl_reg   <= mpl_next;
            mcand_reg <= mcand_next;
            div_reg   <= div_next;
            rem_reg   <= rem_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
            sat_reg   <= sat_next;
        end
    end

    assign acc         = acc_reg;
    assign stat.done   = done_reg;
    assign stat.sat    = sat_reg;
    assign stat.rem_nz = rem_reg != '0;

endmodule

[rtl/core/drt_ctrl.sv]
// Sequencer: transfer state, average check and token bucket over the shared unit.
module drt_ctrl #(
    parameter int TICKS_PER_SECOND = 1000000,
    parameter int ACC_W            = 68
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [drt_pkg::OP_W-1:0]    item_op,
    input  logic [drt_pkg::DELTA_W-1:0] item_delta,
    input  logic [drt_pkg::TIME_W-1:0]  item_now,
    input  logic [drt_pkg::RATE_W-1:0]  avg_rate,
    input  logic [drt_pkg::RATE_W-1:0]  peak_rate,
    input  logic [drt_pkg::RATE_W-1:0]  bucket_limit,
    output drt_pkg::unit_cmd_t          cmd,
    output logic [ACC_W-1:0]            dividend,
    input  drt_pkg::unit_stat_t         stat,
    input  logic [ACC_W-1:0]            acc,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [drt_pkg::WAIT_W-1:0]  res_wait,
    output logic                        res_by_peak,
    output logic                        res_not_reg
);

    localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);
    localparam logic [drt_pkg::STEP_W-1:0] TICK_STEPS = drt_pkg::STEP_W'(TICK_W);
    localparam logic [drt_pkg::RATE_W-1:0] TICKS      = drt_pkg::RATE_W'(TICKS_PER_SECOND);
    localparam int LW  = drt_pkg::LEVEL_W;
    localparam int TW  = drt_pkg::TIME_W;
    localparam int QA  = drt_pkg::AVG_Q_BITS;
    localparam int QP  = drt_pkg::PEAK_Q_BITS;
    localparam int CW  = drt_pkg::SAT_MIN_W;
    localparam logic [63:0] LEVEL_MIN_EXT = {{3{1'b1}}, {(LW-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ACHK, S_AMUL, S_ADIV, S_AEVAL, S_PCHK, S_FMUL,
        S_LMUL, S_DMUL, S_FILL, S_DEBIT, S_PNEG, S_PDIV, S_OUT
    } state_t;

    state_t                         state_reg, state_next;
    logic [drt_pkg::OP_W-1:0]       op_reg, op_next;
    logic [drt_pkg::DELTA_W-1:0]    delta_reg, delta_next;
    logic [TW-1:0]                  now_reg, now_next;
    logic [TW-1:0]                  start_reg, start_next;
    logic [TW-1:0]                  last_fill_reg, last_fill_next;
    logic [TW-1:0]                  progress_reg, progress_next;
    logic [LW-1:0]                  level_reg, level_next;
    logic [drt_pkg::ACTIVE_W-1:0]   active_reg, active_next;
    logic [TW-1:0]                  elapsed_reg, elapsed_next;
    logic [QA:0]                    ideal_reg, ideal_next;
    logic [CW-1:0]                  add_reg, add_next;
    logic [drt_pkg::LIM_W-1:0]      lim_reg, lim_next;
    logic [CW-1:0]                  debit_reg, debit_next;
    logic [drt_pkg::WAIT_W-1:0]     wait_reg, wait_next;
    logic                           peak_reg, peak_next;
    logic                           nreg_reg, nreg_next;
    logic                           out_valid_reg, out_valid_next;
    logic [drt_pkg::WAIT_W-1:0]     out_wait_reg, out_wait_next;
    logic                           out_peak_reg, out_peak_next;
    logic                           out_nreg_reg, out_nreg_next;

    always_comb
    begin
        logic [TW:0]     psum;
        logic [TW-1:0]   fill_ticks;
        logic [63:0]     lvl_ext;
        logic [63:0]     fill_sum;
        logic [63:0]     deb_diff;
        logic [QA+1:0]   adiff;
        logic [QP:0]     pq;
        logic [CW-1:0]   mag;

        state_next     = state_reg;
        op_next        = op_reg;
        delta_next     = delta_reg;
        now_next       = now_reg;
        start_next     = start_reg;
        last_fill_next = last_fill_reg;
        progress_next  = progress_reg;
        level_next     = level_reg;
        active_next    = active_reg;
        elapsed_next   = elapsed_reg;
        ideal_next     = ideal_reg;
        add_next       = add_reg;
        lim_next       = lim_reg;
        debit_next     = debit_reg;
        wait_next      = wait_reg;
        peak_next      = peak_reg;
        nreg_next      = nreg_reg;
        out_valid_next = out_valid_reg;
        out_wait_next  = out_wait_reg;
        out_peak_next  = out_peak_reg;
        out_nreg_next  = out_nreg_reg;
        cmd            = '0;
        dividend       = '0;

        psum       = {1'b0, progress_reg} + (TW+1)'(delta_reg);
        fill_ticks = (now_reg >= last_fill_reg) ? now_reg - last_fill_reg : '0;
        lvl_ext    = {{(64-LW){level_reg[LW-1]}}, level_reg};
        fill_sum   = lvl_ext + 64'(add_reg);
        deb_diff   = lvl_ext - 64'(debit_reg);
        adiff      = {1'b0, ideal_reg} - (QA+2)'(elapsed_reg);
        pq         = {1'b0, acc[QP-1:0]} + (QP+1)'(stat.rem_nz);
        mag        = CW'(-lvl_ext);

        if (out_valid_reg && res_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next    = item_op;
                    delta_next = item_delta;
                    now_next   = item_now;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                wait_next  = '0;
                peak_next  = 1'b0;
                nreg_next  = 1'b0;
                state_next = S_OUT;
                unique case (op_reg)
                    drt_pkg::OP_START:
                    begin
                        if (active_reg == '0)
                        begin
                            start_next     = now_reg;
                            last_fill_next = now_reg;
                            progress_next  = '0;
                            level_next     = '0;
                        end
                        if (active_reg != '1)
                            active_next = active_reg + 1'b1;
                    end
                    drt_pkg::OP_END:
                    begin
                        if (active_reg == '0)
                            nreg_next = 1'b1;
                        else
                            active_next = active_reg - 1'b1;
                    end
                    drt_pkg::OP_PROGRESS:
                    begin
                        if (active_reg == '0)
                            nreg_next = 1'b1;
                        else
                        begin
                            progress_next = psum[TW] ? '1 : psum[TW-1:0];
                            elapsed_next  = (now_reg >= start_reg) ? now_reg - start_reg : '0;
                            state_next    = S_ACHK;
                        end
                    end
                    default:
                    begin
                        nreg_next = 1'b0;
                    end
                endcase
            end
            S_ACHK:
            begin
                if (avg_rate != '0)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = drt_pkg::UOP_MUL;
                    cmd.steps  = TICK_STEPS;
                    cmd.mcand  = progress_reg;
                    cmd.mplier = TICKS;
                    state_next = S_AMUL;
                end
                else
                    state_next = S_PCHK;
            end
            S_AMUL:
            begin
                if (stat.done)
                begin
                    cmd.start   = 1'b1;
                    cmd.op      = drt_pkg::UOP_DIV;
                    cmd.steps   = drt_pkg::STEP_W'(QA);
                    cmd.divisor = avg_rate;
                    dividend    = acc;
                    state_next  = S_ADIV;
                end
            end
            S_ADIV:
            begin
                if (stat.done)
                begin
                    if (stat.sat)
                    begin
                        wait_next  = '1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ideal_next = {1'b0, acc[QA-1:0]} + (QA+1)'(stat.rem_nz);
                        state_next = S_AEVAL;
                    end
                end
            end
            S_AEVAL:
            begin
                // positive difference: ideal finish lies ahead of elapsed time
                if (!adiff[QA+1] && adiff != '0)
                begin
                    wait_next  = (|adiff[QA:drt_pkg::WAIT_W]) ? '1 : adiff[drt_pkg::WAIT_W-1:0];
                    state_next = S_OUT;
                end
                else
                    state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (peak_rate != '0 && bucket_limit != '0)
                begin
                    cmd.start      = 1'b1;
                    cmd.op         = drt_pkg::UOP_MULSAT;
                    cmd.steps      = drt_pkg::STEP_W'(drt_pkg::RATE_W);
                    cmd.mcand      = fill_ticks;
                    cmd.mplier     = peak_rate;
                    last_fill_next = now_reg;
                    state_next     = S_FMUL;
                end
                else
                    state_next = S_OUT;
            end
            S_FMUL:
            begin
                if (stat.done)
                begin
                    add_next   = acc[CW-1:0];
                    cmd.start  = 1'b1;
                    cmd.op     = drt_pkg::UOP_MULSAT;
                    cmd.steps  = TICK_STEPS;
                    cmd.mcand  = TW'(bucket_limit);
                    cmd.mplier = TICKS;
                    state_next = S_LMUL;
                end
            end
            S_LMUL:
            begin
                if (stat.done)
                begin
                    lim_next   = (|acc[ACC_W-1:drt_pkg::LIM_W]) ? '1 : acc[drt_pkg::LIM_W-1:0];
                    cmd.start  = 1'b1;
                    cmd.op     = drt_pkg::UOP_MULSAT;
                    cmd.steps  = TICK_STEPS;
                    cmd.mcand  = TW'(delta_reg);
                    cmd.mplier = TICKS;
                    state_next = S_DMUL;
                end
            end
            S_DMUL:
            begin
                if (stat.done)
                begin
                    debit_next = acc[CW-1:0];
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                // refill, clamped at the limit (also when already above it)
                if ($signed(fill_sum) >= $signed(64'(lim_reg)))
                    level_next = LW'(lim_reg);
                else
                    level_next = fill_sum[LW-1:0];
                state_next = S_DEBIT;
            end
            S_DEBIT:
            begin
                if ($signed(deb_diff) < $signed(LEVEL_MIN_EXT))
                    level_next = LEVEL_MIN_EXT[LW-1:0];
                else
                    level_next = deb_diff[LW-1:0];
                state_next = deb_diff[63] ? S_PNEG : S_OUT;
            end
            S_PNEG:
            begin
                cmd.start   = 1'b1;
                cmd.op      = drt_pkg::UOP_DIV;
                cmd.steps   = drt_pkg::STEP_W'(QP);
                cmd.divisor = peak_rate;
                dividend    = ACC_W'(mag);
                state_next  = S_PDIV;
            end
            S_PDIV:
            begin
                if (stat.done)
                begin
                    wait_next  = (stat.sat || pq[QP]) ? '1 : pq[QP-1:0];
                    peak_next  = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next = 1'b1;
                    out_wait_next  = wait_reg;
                    out_peak_next  = peak_reg;
                    out_nreg_next  = nreg_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            delta_reg     <= '0;
            now_reg       <= '0;
            start_reg     <= '0;
            last_fill_reg <= '0;
            progress_reg  <= '0;
            level_reg     <= '0;
            active_reg    <= '0;
            elapsed_reg   <= '0;
            ideal_reg     <= '0;
            add_reg       <= '0;
            lim_reg       <= '0;
            debit_reg     <= '0;
            wait_reg      <= '0;
            peak_reg      <= 1'b0;
            nreg_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_wait_reg  <= '0;
            out_peak_reg  <= 1'b0;
            out_nreg_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            delta_reg     <= delta_next;
            now_reg       <= now_next;
            start_reg     <= start_next;
            last_fill_reg <= last_fill_next;
            progress_reg  <= progress_next;
            level_reg     <= level_next;
            active_reg    <= active_next;
            elapsed_reg   <= elapsed_next;
            ideal_reg     <= ideal_next;
            add_reg       <= add_next;
            lim_reg       <= lim_next;
            debit_reg     <= debit_next;
            wait_reg      <= wait_next;
            peak_reg      <= peak_next;
            nreg_reg      <= nreg_next;
            out_valid_reg <= out_valid_next;
            out_wait_reg  <= out_wait_next;
            out_peak_reg  <= out_peak_next;
            out_nreg_reg  <= out_nreg_next;
        end
    end

    assign item_ready  = state_reg == S_IDLE;
    assign res_valid   = out_valid_reg;
    assign res_wait    = out_wait_reg;
    assign res_by_peak = out_peak_reg;
    assign res_not_reg = out_nreg_reg;

endmodule

[rtl/core/dual_rate_transfer_throttle_core.sv]
// Top level of the dual-rate transfer throttle: register file, sequencer and shared unit.
//
// item:   one request per transfer event (op, delta_bytes, now_us). op selects
//         progress, transfer start or transfer end; now_us is a monotonic tick count.
// result: exactly one response per request: wait_us to pause (0 = proceed),
//         by_peak when the wait came from the token bucket, not_registered when
//         progress or end arrived with no transfer active.
// cfg:    register writes (index 0 avg_rate, 1 peak_rate, 2 bucket_limit),
//         always ready, taking effect at once; other indexes are dropped.
// One request at a time; item.ready is low from acceptance until the response
// is loaded into the output register, and rises again at that same edge.
// Start, end and unregistered progress requests go from decode straight to the
// output state. Progress requests iterate on one shift-add multiplier /
// restoring divider, one bit per cycle: the average check multiplies by
// TICKS_PER_SECOND over its bits (20 by default) and divides, ending there
// when the average limit sets the wait; the token bucket, when consulted, adds
// three multiplies and, when it runs into deficit, a divide.
// Reset clears the registers, the transfer state and the output register.
// A stalled response holds in the output register; the block then finishes
// the next request's work and waits before loading its response.
module dual_rate_transfer_throttle_core #(
    parameter int TICKS_PER_SECOND = 1000000
) (
    input  logic          clk,
    input  logic          rst_n,
    drt_item_if.sink      item,
    drt_result_if.source  result,
    drt_cfg_if.sink       cfg
);

    localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W = drt_pkg::TIME_W + TICK_W;
    localparam int ACC_W  = (PROD_W > drt_pkg::SAT_MIN_W) ? PROD_W : drt_pkg::SAT_MIN_W;

    logic [drt_pkg::RATE_W-1:0] avg_rate_reg, avg_rate_next;
    logic [drt_pkg::RATE_W-1:0] peak_rate_reg, peak_rate_next;
    logic [drt_pkg::RATE_W-1:0] limit_reg, limit_next;

    drt_pkg::unit_cmd_t  cmd;
    drt_pkg::unit_stat_t stat;
    logic [ACC_W-1:0]    dividend;
    logic [ACC_W-1:0]    acc;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        avg_rate_next  = avg_rate_reg;
        peak_rate_next = peak_rate_reg;
        limit_next     = limit_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                drt_pkg::CFG_AVG_RATE:     avg_rate_next  = cfg.data;
                drt_pkg::CFG_PEAK_RATE:    peak_rate_next = cfg.data;
                drt_pkg::CFG_BUCKET_LIMIT: limit_next     = cfg.data;
                default:                   limit_next     = limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_rate_reg  <= '0;
            peak_rate_reg <= '0;
            limit_reg     <= '0;
        end
        else
        begin
            avg_rate_reg  <= avg_rate_next;
            peak_rate_reg <= peak_rate_next;
            limit_reg     <= limit_next;
        end
    end

    drt_ctrl #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .ACC_W            (ACC_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .item_op      (item.op),
        .item_delta   (item.delta_bytes),
        .item_now     (item.now_us),
        .avg_rate     (avg_rate_reg),
        .peak_rate    (peak_rate_reg),
        .bucket_limit (limit_reg),
        .cmd          (cmd),
        .dividend     (dividend),
        .stat         (stat),
        .acc          (acc),
        .res_valid    (result.valid),
        .res_ready    (result.ready),
        .res_wait     (result.wait_us),
        .res_by_peak  (result.by_peak),
        .res_not_reg  (result.not_registered)
    );

    drt_unit #(
        .ACC_W (ACC_W)
    ) u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .dividend (dividend),
        .stat     (stat),
        .acc      (acc)
    );

endmodule

[rtl/core/drt_checker.sv]
// Port-level checks on the throttle core, bound to the top level.
`include "assert_macros.svh"

module drt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_ready,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic [drt_pkg::WAIT_W-1:0] wait_us,
    input logic                       by_peak,
    input logic                       not_registered
);

    // one request in flight at a time
    `DRT_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "request accepted while busy")
    // a bucket deficit always rounds up to a nonzero pause
    `DRT_ASSERT_NOW(a_peak_wait_nonzero, result_valid && by_peak, wait_us != '0 && !not_registered, "bucket response without pause")
    `DRT_ASSERT_NOW(a_unreg_no_wait, result_valid && not_registered, wait_us == '0 && !by_peak, "unregistered response carries a pause")
    `DRT_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(wait_us) && $stable(by_peak) && $stable(not_registered), "stalled response changed")

endmodule

bind dual_rate_transfer_throttle_core drt_checker u_drt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .wait_us        (result.wait_us),
    .by_peak        (result.by_peak),
    .not_registered (result.not_registered)
);
